// ===== src/mimw_pkg.sv =====
// ----------------------------------------------------------------------------
// mimw_pkg
// Shared types and constants of the minimum-image wrap block.
// ----------------------------------------------------------------------------
package mimw_pkg;

	// Displacement words are signed Q15.16.
	localparam int DISP_WIDTH = 32;

	// Matrix entries are 21-bit two's complement fields, three to a row.
	localparam int MAT_BITS = 21;
	localparam int ROW_BITS = 3 * MAT_BITS;

	// Configuration port.
	localparam int CFG_DATA_W = ROW_BITS;
	localparam int CFG_IDX_W  = 3;

	localparam logic [CFG_IDX_W-1:0] REG_CELL_ROW0     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_ROW1     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CELL_ROW2     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW0      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW1      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_ROW2      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_PERIODIC_MASK = 3'd6;

	localparam logic [2:0] MASK_RESET = 3'b111;

	// Fractional coordinates are held 63 bits wide: they are clamped to +-2^61.
	localparam int FRAC_W = 63;
	// Width in which the fractional clamp is compared.
	localparam int SAT_W  = 64;
	// Fractional coordinates are split at this bit for the second transform.
	localparam int LO_BITS = 32;

	// Pipeline depth of the two transform units.
	localparam int FRAC_STAGES = 4;
	localparam int CART_STAGES = 3;
	localparam int NUM_STAGES  = FRAC_STAGES + CART_STAGES;

	typedef struct packed {
		logic signed [DISP_WIDTH-1:0] disp_x;
		logic signed [DISP_WIDTH-1:0] disp_y;
		logic signed [DISP_WIDTH-1:0] disp_z;
	} disp_t;

	typedef struct packed {
		logic signed [DISP_WIDTH-1:0] wrapped_x;
		logic signed [DISP_WIDTH-1:0] wrapped_y;
		logic signed [DISP_WIDTH-1:0] wrapped_z;
	} wrap_t;

	typedef struct packed {
		logic [2:0][ROW_BITS-1:0] cell_mat;
		logic [2:0][ROW_BITS-1:0] inv;
		logic [2:0]               periodic_mask;
	} cfg_t;

	typedef struct packed {
		logic [FRAC_STAGES-1:0] frac_en;
		logic [CART_STAGES-1:0] cart_en;
	} pipe_ctl_t;

	typedef logic [2:0][FRAC_W-1:0] frac_vec_t;

	// Column col of a packed matrix row, bits 20..0 being column 0.
	function automatic logic signed [MAT_BITS-1:0] mat_entry(
		input logic [ROW_BITS-1:0] row,
		input int                  col
	);
		return row[col*MAT_BITS +: MAT_BITS];
	endfunction

endpackage

// ===== src/mimw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mimw_cfg_regs
// Holds the cell matrix, its inverse and the periodic axis mask.
// ----------------------------------------------------------------------------
module mimw_cfg_regs import mimw_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_t                  cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cell_mat      <= '0;
			cfg_q.inv           <= '0;
			cfg_q.periodic_mask <= MASK_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_CELL_ROW0:     cfg_q.cell_mat[0]   <= cfg_wdata;
				REG_CELL_ROW1:     cfg_q.cell_mat[1]   <= cfg_wdata;
				REG_CELL_ROW2:     cfg_q.cell_mat[2]   <= cfg_wdata;
				REG_INV_ROW0:      cfg_q.inv[0]        <= cfg_wdata;
				REG_INV_ROW1:      cfg_q.inv[1]        <= cfg_wdata;
				REG_INV_ROW2:      cfg_q.inv[2]        <= cfg_wdata;
				REG_PERIODIC_MASK: cfg_q.periodic_mask <= cfg_wdata[2:0];
				default: begin
					// Writes beyond the register list are dropped.
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/mimw_pipe_ctrl.sv =====
// ----------------------------------------------------------------------------
// mimw_pipe_ctrl
// Valid bits of the datapath stages and the per-stage load enables.
// ----------------------------------------------------------------------------
module mimw_pipe_ctrl import mimw_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output pipe_ctl_t ctl
);

	logic [NUM_STAGES-1:0] vld_q;
	logic [NUM_STAGES-1:0] en;

	// A stage loads when it is empty or when its word moves on, so bubbles
	// collapse even while the output is stalled.
	always_comb begin
		en[NUM_STAGES-1] = !vld_q[NUM_STAGES-1] || out_ready;
		for (int k = NUM_STAGES - 2; k >= 0; k--) begin
			en[k] = !vld_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (en[0]) begin
				vld_q[0] <= in_valid;
			end
			for (int k = 1; k < NUM_STAGES; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign in_ready    = en[0];
	assign out_valid   = vld_q[NUM_STAGES-1];
	assign ctl.frac_en = en[FRAC_STAGES-1:0];
	assign ctl.cart_en = en[NUM_STAGES-1:FRAC_STAGES];

`ifndef ASSERT_OFF
	// A stalled stage keeps its word.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ((vld_q & $past(vld_q & ~en)) == $past(vld_q & ~en)))
		else $error("stalled stage lost its word");

	// At most one word enters per cycle, so occupancy grows by one at most.
	a_no_dup: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> ($countones(vld_q) <= $past($countones(vld_q)) + 1))
		else $error("pipeline occupancy grew by more than one");

	// An empty pipeline always takes a word.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q == '0) |-> in_ready)
		else $error("empty pipeline not ready");
`endif

endmodule

// ===== src/mimw_frac_xform.sv =====
// ----------------------------------------------------------------------------
// mimw_frac_xform
// Inverse-cell transform to fractional coordinates, clamp and periodic wrap.
// ----------------------------------------------------------------------------
module mimw_frac_xform import mimw_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic                   clk,
	input  logic [FRAC_STAGES-1:0] en,
	input  disp_t                  disp,
	input  cfg_t                   cfg,
	output frac_vec_t              frac
);

	localparam int S1     = 36 - FRAC_BITS;
	localparam int PROD_W = DISP_WIDTH + MAT_BITS;
	localparam int SUM_W  = PROD_W + 2;

	localparam logic signed [SAT_W-1:0]  F_LIM = SAT_W'(1) <<< 61;
	localparam logic signed [FRAC_W-1:0] HALF  = FRAC_W'(1) <<< (FRAC_BITS - 1);

	logic signed [DISP_WIDTH-1:0] d_s1   [3];
	logic signed [PROD_W-1:0]     p_s2   [3][3];
	logic signed [SUM_W-1:0]      sum_s3 [3];
	logic [FRAC_W-1:0]            f_s4   [3];

	logic signed [SUM_W-1:0]  sh_c   [3];
	logic signed [SAT_W-1:0]  ext_c  [3];
	logic signed [FRAC_W-1:0] clmp_c [3];
	logic signed [FRAC_W-1:0] bias_c [3];
	logic signed [FRAC_W-1:0] f_c    [3];

	// Floor shift, clamp to +-2^61, then wrap periodic axes into [-0.5, 0.5).
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sh_c[i]  = sum_s3[i] >>> S1;
			ext_c[i] = SAT_W'(sh_c[i]);
			if (ext_c[i] > F_LIM) begin
				clmp_c[i] = FRAC_W'(F_LIM);
			end else if (ext_c[i] < -F_LIM) begin
				clmp_c[i] = FRAC_W'(-F_LIM);
			end else begin
				clmp_c[i] = FRAC_W'(ext_c[i]);
			end
			bias_c[i] = clmp_c[i] + HALF;
			if (cfg.periodic_mask[i]) begin
				f_c[i] = $signed({{(FRAC_W-FRAC_BITS){1'b0}}, bias_c[i][FRAC_BITS-1:0]})
					- HALF;
			end else begin
				f_c[i] = clmp_c[i];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			d_s1[0] <= disp.disp_x;
			d_s1[1] <= disp.disp_y;
			d_s1[2] <= disp.disp_z;
		end
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p_s2[i][j] <= d_s1[j] * mat_entry(cfg.inv[i], j);
				end
			end
		end
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				sum_s3[i] <= SUM_W'(p_s2[i][0]) + SUM_W'(p_s2[i][1]) + SUM_W'(p_s2[i][2]);
			end
		end
		if (en[3]) begin
			for (int i = 0; i < 3; i++) begin
				f_s4[i] <= f_c[i];
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			frac[i] = f_s4[i];
		end
	end

endmodule

// ===== src/mimw_cart_xform.sv =====
// ----------------------------------------------------------------------------
// mimw_cart_xform
// Cell transform back to Cartesian displacement, with output saturation.
// ----------------------------------------------------------------------------
module mimw_cart_xform import mimw_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic                   clk,
	input  logic [CART_STAGES-1:0] en,
	input  frac_vec_t              frac,
	input  cfg_t                   cfg,
	output wrap_t                  wrapped
);

	localparam int S2    = FRAC_BITS - 6;
	localparam int HI_BITS = FRAC_W - LO_BITS;
	localparam int HI_W  = HI_BITS + MAT_BITS;
	localparam int LO_W  = LO_BITS + 1 + MAT_BITS;
	localparam int HS_W  = HI_W + 2;
	localparam int LS_W  = LO_W + 2;
	localparam int TOT_W = HS_W + LO_BITS + 1;

	localparam logic signed [TOT_W-1:0] O_MAX = (TOT_W'(1) <<< (DISP_WIDTH - 1)) - TOT_W'(1);
	localparam logic signed [TOT_W-1:0] O_MIN = -O_MAX - TOT_W'(1);

	logic signed [HI_W-1:0]       hi_s5   [3][3];
	logic signed [LO_W-1:0]       lo_s5   [3][3];
	logic signed [HS_W-1:0]       hsum_s6 [3];
	logic signed [LS_W-1:0]       lsum_s6 [3];
	logic signed [DISP_WIDTH-1:0] w_s7    [3];

	logic signed [TOT_W-1:0]      tot_c [3];
	logic signed [TOT_W-1:0]      sh_c  [3];
	logic signed [DISP_WIDTH-1:0] w_c   [3];

	// Each fractional coordinate is split into a signed upper part and an
	// unsigned lower word so that no multiplier exceeds 33 by 21 bits.
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			tot_c[i] = TOT_W'($signed({hsum_s6[i], {LO_BITS{1'b0}}})) + TOT_W'(lsum_s6[i]);
			sh_c[i]  = tot_c[i] >>> S2;
			if (sh_c[i] > O_MAX) begin
				w_c[i] = DISP_WIDTH'(O_MAX);
			end else if (sh_c[i] < O_MIN) begin
				w_c[i] = DISP_WIDTH'(O_MIN);
			end else begin
				w_c[i] = DISP_WIDTH'(sh_c[i]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					hi_s5[i][j] <= $signed(frac[j][FRAC_W-1:LO_BITS])
						* mat_entry(cfg.cell_mat[i], j);
					lo_s5[i][j] <= $signed({1'b0, frac[j][LO_BITS-1:0]})
						* mat_entry(cfg.cell_mat[i], j);
				end
			end
		end
		if (en[1]) begin
			for (int i = 0; i < 3; i++) begin
				hsum_s6[i] <= HS_W'(hi_s5[i][0]) + HS_W'(hi_s5[i][1]) + HS_W'(hi_s5[i][2]);
				lsum_s6[i] <= LS_W'(lo_s5[i][0]) + LS_W'(lo_s5[i][1]) + LS_W'(lo_s5[i][2]);
			end
		end
		if (en[2]) begin
			for (int i = 0; i < 3; i++) begin
				w_s7[i] <= w_c[i];
			end
		end
	end

	assign wrapped.wrapped_x = w_s7[0];
	assign wrapped.wrapped_y = w_s7[1];
	assign wrapped.wrapped_z = w_s7[2];

`ifndef ASSERT_OFF
	// The output register holds its word while the consumer stalls.
	a_out_hold: assert property (@(posedge clk)
		!en[CART_STAGES-1] |=> $stable(wrapped))
		else $error("output word changed while stalled");
`endif

endmodule

// ===== src/minimum_image_wrap_top.sv =====
// ----------------------------------------------------------------------------
// minimum_image_wrap_top
// Minimum-image wrap of displacement vectors under a triclinic periodic cell.
// ----------------------------------------------------------------------------
//
//  Channel     Handshake                     Payload
//  ---------   ---------------------------   ---------------------------------
//  disp        disp_valid / disp_ready       disp_x, disp_y, disp_z (Q15.16)
//  wrapped     wrap_valid / wrap_ready       wrapped_x, _y, _z (Q15.16, sat)
//  config      cfg_wr_en, cfg_addr           cfg_wdata (63 bits, write only)
//
//  One word is accepted every cycle unless an output stall has filled every
//  stage. A result is presented once it has passed through the seven register
//  stages of the two matrix transforms.
//  Reset clears the valid bits and loads zero matrices and a full periodic
//  mask; the datapath registers are not reset.
//  Each stage loads when it is empty or its word moves on, so a stall at the
//  output fills bubbles first and only then holds the input.
//
// The block turns each displacement into fractional coordinates with the
// inverse cell matrix, removes the nearest integer on every periodic axis,
// and maps the result back with the cell matrix. The first transform keeps
// FRAC_BITS fraction bits in the fractional coordinates, rounding toward minus
// infinity and clamping to +-2^61. The second transform floors to 16 fraction
// bits and saturates to the displacement range.
// ----------------------------------------------------------------------------
module minimum_image_wrap_top import mimw_pkg::*; #(
	parameter int FRAC_BITS = 20
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  disp_valid,
	output logic                  disp_ready,
	input  disp_t                 disp,

	output logic                  wrap_valid,
	input  logic                  wrap_ready,
	output wrap_t                 wrapped,

	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_addr,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_t      cfg;
	pipe_ctl_t ctl;
	frac_vec_t frac;

	// Configuration must be written only while the pipeline is empty (the block
	// does not enforce this), so the transforms read the registers directly.
	mimw_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Valid bits of all seven stages and their load enables.
	mimw_pipe_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (disp_valid),
		.in_ready  (disp_ready),
		.out_valid (wrap_valid),
		.out_ready (wrap_ready),
		.ctl       (ctl)
	);

	// Stages one to four: input register, products, row sums, clamp and wrap.
	mimw_frac_xform #(
		.FRAC_BITS (FRAC_BITS)
	) u_frac (
		.clk  (clk),
		.en   (ctl.frac_en),
		.disp (disp),
		.cfg  (cfg),
		.frac (frac)
	);

	// Stages five to seven: split products, row sums, rescale and saturate.
	mimw_cart_xform #(
		.FRAC_BITS (FRAC_BITS)
	) u_cart (
		.clk     (clk),
		.en      (ctl.cart_en),
		.frac    (frac),
		.cfg     (cfg),
		.wrapped (wrapped)
	);

endmodule
